>>> rtl/core/opt_pkg.sv
// Shared types, constants and tables for the orbit position tracker.
`timescale 1ns / 1ps
package opt_pkg;

  localparam int ANG_W = 17;                         // signed angle, 1/128 degree
  localparam logic [16:0] FULL_TURN = 17'd46080;     // 360 degrees
  localparam logic signed [18:0] PSI_LIM = 19'sd11520; // 90 degrees
  localparam logic [15:0] RECIP_45 = 16'd46604;      // ceil(2^21 / 45)
  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [34:0] POS_MAX = 35'sd4294967295;
  localparam logic signed [34:0] POS_MIN = -35'sd4294967296;

  typedef struct packed {
    logic                    start;
    logic signed [ANG_W-1:0] angle;
  } cordic_req_t;

  // arctan(2^-i) as a 2^32-per-turn binary angle
  function automatic logic [29:0] atan_bin(input logic [4:0] idx);
    logic [29:0] v;
    unique case (idx)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/core/opt_in_if.sv
// Command channel: one word per orbit update.
`timescale 1ns / 1ps
interface opt_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [2:0]         field_mask;
  logic signed [32:0] radius_value;
  logic signed [17:0] theta_value;
  logic signed [17:0] psi_value;

  modport source (output valid, mode, field_mask, radius_value, theta_value, psi_value,
                  input ready);
  modport sink (input valid, mode, field_mask, radius_value, theta_value, psi_value,
                output ready);
endinterface

>>> rtl/core/opt_out_if.sv
// Result channel: position and current orbit fields, one word per update.
`timescale 1ns / 1ps
interface opt_out_if;
  logic               valid;
  logic               ready;
  logic signed [32:0] pos_x;
  logic signed [32:0] pos_y;
  logic signed [32:0] pos_z;
  logic [31:0]        radius_now;
  logic [15:0]        theta_now;
  logic signed [14:0] psi_now;

  modport source (output valid, pos_x, pos_y, pos_z, radius_now, theta_now, psi_now,
                  input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, radius_now, theta_now, psi_now,
                output ready);
endinterface

>>> rtl/core/opt_cordic.sv
// Iterative rotation-mode CORDIC: cosine and sine of an angle in 1/128 degree.
`timescale 1ns / 1ps
module opt_cordic #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  opt_pkg::cordic_req_t req,
  output logic                done,
  output logic signed [33:0]  cos_q,
  output logic signed [33:0]  sin_q
);
  import opt_pkg::*;

  localparam int CW = $clog2(CORDIC_STEPS);

  typedef enum logic [1:0] {C_IDLE, C_QUO, C_MAP, C_ROT} cstate_t;

  cstate_t            st;
  logic [15:0]        mag;
  logic               neg;
  logic               flip;
  logic [10:0]        quo;
  logic signed [33:0] x, y, z;
  logic [CW-1:0]      cnt;

  // floor((r*2^22 + 22) / 45) for each remainder r
  logic [21:0] frac_tab [45];
  for (genvar g = 0; g < 45; g++) begin : g_frac
    localparam logic [21:0] V = 22'((64'(g) * 64'd4194304 + 64'd22) / 64'd45);
    assign frac_tab[g] = V;
  end

  logic [31:0] quo_prod;
  logic [15:0] rem16;
  logic [5:0]  rem;
  logic [31:0] bang, bang_s, bang_f;
  logic        flip_c;
  logic signed [33:0] xs, ys, atn, x_new, y_new, z_new;

  always_comb begin
    quo_prod = mag * RECIP_45;
    rem16    = mag - 16'(quo * 11'd45);
    rem      = rem16[5:0];
    bang     = {quo[9:0], 22'b0} + {10'b0, frac_tab[rem]};
    bang_s   = neg ? (32'd0 - bang) : bang;
    flip_c   = bang_s[31] ^ bang_s[30];
    bang_f   = {bang_s[31] ^ flip_c, bang_s[30:0]};
    xs       = x >>> cnt;
    ys       = y >>> cnt;
    atn      = {4'b0, atan_bin(5'(cnt))};
    if (!z[33]) begin
      x_new = x - ys;
      y_new = y + xs;
      z_new = z - atn;
    end else begin
      x_new = x + ys;
      y_new = y - xs;
      z_new = z + atn;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= C_IDLE;
      done <= 1'b0;
    end else begin
      done <= (st == C_ROT) && (cnt == CW'(CORDIC_STEPS - 1));
      unique case (st)
        C_IDLE: begin
          if (req.start) begin
            neg <= req.angle[ANG_W-1];
            mag <= req.angle[ANG_W-1] ? 16'(-req.angle) : req.angle[15:0];
            st  <= C_QUO;
          end
        end
        C_QUO: begin
          quo <= quo_prod[31:21];
          st  <= C_MAP;
        end
        C_MAP: begin
          flip <= flip_c;
          x    <= GAIN_Q30;
          y    <= '0;
          z    <= {{2{bang_f[31]}}, bang_f};
          cnt  <= '0;
          st   <= C_ROT;
        end
        C_ROT: begin
          x   <= x_new;
          y   <= y_new;
          z   <= z_new;
          cnt <= cnt + 1'b1;
          if (cnt == CW'(CORDIC_STEPS - 1)) begin
            cos_q <= flip ? -x_new : x_new;
            sin_q <= flip ? -y_new : y_new;
            st    <= C_IDLE;
          end
        end
        default: st <= C_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/orbit_position_tracker.sv
// Orbit position tracker: update r/theta/psi, then Cartesian position by CORDIC.
// Usage:
//   cmd carries one update word (mode, field_mask, radius/theta/psi values).
//   res carries one word per update: pos_x/y/z and the updated r, theta, psi.
//   cmd.ready is high only while no update is in progress; one word at a time.
// Steps from cmd accept to res valid:
//   theta wrapping (one whole turn removed per step, plus a final check),
//   two CORDIC passes (elevation, then azimuth) on the one CORDIC unit, four
//   products on a shared split multiplier, and a write into the output
//   register. The next word is taken once the block is back in idle.
// The result sits in an output register, so a new word is taken while the old
// result waits; a stalled res only holds the block when the next result is
// ready to be written.
// Reset: radius 10.0, theta 0, psi 0, no result pending; ready the next cycle.
`timescale 1ns / 1ps
module orbit_position_tracker #(
  parameter int RADIUS_FRAC_BITS = 16,
  parameter int CORDIC_STEPS     = 16
) (
  input  logic      clk,
  input  logic      rst,
  opt_in_if.sink    cmd,
  opt_out_if.source res
);
  import opt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_WRAP, S_PSI, S_THETA, S_MUL_LO, S_MUL_HI, S_MUL_RND, S_OUT
  } state_t;

  state_t             st;
  logic [31:0]        radius;
  logic [15:0]        azimuth;
  logic signed [14:0] elevation;
  logic signed [18:0] tval;
  cordic_req_t        creq;
  logic               cdone;
  logic signed [33:0] ccos, csin;
  logic signed [33:0] cp, sp, ct, st_q, rc;
  logic signed [32:0] px, py, pz;
  logic [1:0]         op;
  logic signed [67:0] acc;
  logic               out_valid;
  logic               wrap_hi, wrap_lo;

  opt_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .req   (creq),
    .done  (cdone),
    .cos_q (ccos),
    .sin_q (csin)
  );

  // field updates
  logic signed [34:0] r_sum, r_cand;
  logic [31:0]        r_next;
  logic signed [18:0] t_next;
  logic signed [18:0] p_cand;
  logic signed [14:0] p_next;

  always_comb begin
    r_sum  = $signed({3'b0, radius}) + 35'(cmd.radius_value);
    r_cand = cmd.mode ? 35'(cmd.radius_value) : r_sum;
    if (r_cand < 35'sd1)        r_next = 32'd1;
    else if (r_cand > POS_MAX)  r_next = 32'hFFFF_FFFF;
    else                        r_next = r_cand[31:0];
    t_next = cmd.mode ? 19'(cmd.theta_value)
                      : $signed({3'b0, azimuth}) + 19'(cmd.theta_value);
    p_cand = cmd.mode ? 19'(cmd.psi_value) : 19'(elevation) + 19'(cmd.psi_value);
    if (p_cand > PSI_LIM)       p_next = 15'(PSI_LIM);
    else if (p_cand < -PSI_LIM) p_next = 15'(-PSI_LIM);
    else                        p_next = p_cand[14:0];
  end

  // theta still outside [0, 360]: above 360 / below 0
  assign wrap_hi = tval > $signed({2'b0, FULL_TURN});
  assign wrap_lo = tval < 19'sd0;

  // shared multiplier: 34 x 34 in two halves of the second operand
  logic signed [33:0] mul_a, mul_b;
  logic signed [51:0] p_lo;
  logic signed [50:0] p_hi;
  logic signed [67:0] rnd;
  logic signed [37:0] prod;
  logic signed [32:0] prod_sat;

  always_comb begin
    mul_a = (op[1]) ? rc : $signed({2'b0, radius});
    unique case (op)
      2'd0:    mul_b = cp;
      2'd1:    mul_b = sp;
      2'd2:    mul_b = ct;
      default: mul_b = st_q;
    endcase
    p_lo = mul_a * $signed({1'b0, mul_b[16:0]});
    p_hi = mul_a * $signed(mul_b[33:17]);
    rnd  = (acc + 68'sd536870912) >>> 30;
    prod = rnd[37:0];
    if (rnd > 68'(POS_MAX))      prod_sat = 33'(POS_MAX);
    else if (rnd < 68'(POS_MIN)) prod_sat = 33'(POS_MIN);
    else                         prod_sat = rnd[32:0];
  end

  assign cmd.ready = (st == S_IDLE);
  assign res.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= S_IDLE;
      radius     <= 32'(10) << RADIUS_FRAC_BITS;
      azimuth    <= '0;
      elevation  <= '0;
      creq.start <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      creq.start <= ((st == S_WRAP) && !wrap_hi && !wrap_lo) ||
                    ((st == S_PSI) && cdone);
      if ((st == S_OUT) && (!out_valid || res.ready)) out_valid <= 1'b1;
      else if (res.valid && res.ready)                out_valid <= 1'b0;
      unique case (st)
        S_IDLE: begin
          if (cmd.valid) begin
            if (cmd.field_mask[0]) radius <= r_next;
            if (cmd.field_mask[2]) elevation <= p_next;
            tval <= cmd.field_mask[1] ? t_next : $signed({3'b0, azimuth});
            st   <= S_WRAP;
          end
        end
        S_WRAP: begin
          // one whole turn per cycle; exactly 360 degrees stays
          if (wrap_hi) begin
            tval <= tval - $signed({2'b0, FULL_TURN});
          end else if (wrap_lo) begin
            tval <= tval + $signed({2'b0, FULL_TURN});
          end else begin
            azimuth    <= tval[15:0];
            creq.angle <= 17'(elevation);
            st         <= S_PSI;
          end
        end
        S_PSI: begin
          if (cdone) begin
            cp         <= ccos;
            sp         <= csin;
            creq.angle <= $signed({1'b0, azimuth});
            st         <= S_THETA;
          end
        end
        S_THETA: begin
          if (cdone) begin
            ct   <= ccos;
            st_q <= csin;
            op   <= 2'd0;
            st   <= S_MUL_LO;
          end
        end
        S_MUL_LO: begin
          acc <= 68'(p_lo);
          st  <= S_MUL_HI;
        end
        S_MUL_HI: begin
          acc <= acc + (68'(p_hi) <<< 17);
          st  <= S_MUL_RND;
        end
        S_MUL_RND: begin
          unique case (op)
            2'd0:    rc <= prod[33:0];
            2'd1:    py <= prod_sat;
            2'd2:    px <= prod_sat;
            default: pz <= prod_sat;
          endcase
          op <= op + 2'd1;
          st <= (op == 2'd3) ? S_OUT : S_MUL_LO;
        end
        S_OUT: begin
          if (!out_valid || res.ready) begin
            res.pos_x      <= px;
            res.pos_y      <= py;
            res.pos_z      <= pz;
            res.radius_now <= radius;
            res.theta_now  <= azimuth;
            res.psi_now    <= elevation;
            st             <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  a_radius_nonzero: assert property (@(posedge clk) disable iff (rst)
    radius != 32'd0) else $error("radius reached zero");

  a_psi_range: assert property (@(posedge clk) disable iff (rst)
    (elevation <= 15'(PSI_LIM)) && (elevation >= 15'(-PSI_LIM)))
    else $error("elevation out of range");

  a_theta_range: assert property (@(posedge clk) disable iff (rst)
    azimuth <= FULL_TURN[15:0]) else $error("azimuth out of range");

  a_cordic_done_expected: assert property (@(posedge clk) disable iff (rst)
    cdone |-> (st == S_PSI || st == S_THETA)) else $error("stray CORDIC done");

endmodule
